@@ sv/bbd_pkg.sv @@
// bbd_pkg: shared types, constants and the bilinear pixel function
// for the bggr demosaic block and its checker
// no dependencies
package bbd_pkg;

    localparam int MAX_WIDTH_DEF = 2048;   // default line store depth
    localparam int FW_BITS       = 12;     // frame_width register
    localparam int FH_BITS       = 13;     // frame_height register
    localparam int ROW_BITS      = 12;     // row counters, up to 4095
    localparam int CFG_BITS      = 13;     // config write data
    localparam int HEIGHT_LIMIT  = 4096;

    localparam logic [FW_BITS-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [FH_BITS-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_DRAIN  = 1'b1
    } t_kind;

    typedef logic [7:0] t_pix;

    // 3x3 window, u = row above, d = row below
    typedef struct packed {
        t_pix ul, u, ur;
        t_pix l,  c, rt;
        t_pix dl, d, dr;
    } t_win;

    // position of the output pixel inside the frame
    typedef struct packed {
        logic row_odd;
        logic col_odd;
        logic not_top;
        logic not_left;
        logic not_right;
        logic not_bottom;
    } t_pix_pos;

    typedef struct packed {
        t_pix red;
        t_pix green;
        t_pix blue;
    } t_rgb;

    function automatic t_pix avg2(t_pix a, t_pix b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8:1];
    endfunction

    function automatic t_pix avg4(t_pix a, t_pix b, t_pix c, t_pix d);
        logic [9:0] s;
        s = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d};
        return s[9:2];
    endfunction

    function automatic t_rgb demosaic(t_win w, t_pix_pos p);
        t_rgb o;
        o = '0;
        if (!p.row_odd) begin
            if (!p.col_odd) begin
                // blue site
                if (p.not_top && p.not_left) begin
                    o.red   = avg4(w.ul, w.ur, w.dl, w.dr);
                    o.green = avg4(w.l, w.rt, w.d, w.u);
                end else begin
                    o.red   = w.dr;
                    o.green = avg2(w.rt, w.d);
                end
                o.blue = w.c;
            end else begin
                // green site on a blue row
                o.green = w.c;
                if (p.not_top && p.not_right) begin
                    o.red  = avg2(w.d, w.u);
                    o.blue = avg2(w.l, w.rt);
                end else begin
                    o.red  = w.d;
                    o.blue = w.l;
                end
            end
        end else begin
            if (!p.col_odd) begin
                // green site on a red row
                o.green = w.c;
                if (p.not_bottom && p.not_left) begin
                    o.red  = avg2(w.l, w.rt);
                    o.blue = avg2(w.d, w.u);
                end else begin
                    o.red  = w.rt;
                    o.blue = w.u;
                end
            end else begin
                // red site
                o.red = w.c;
                if (p.not_bottom && p.not_right) begin
                    o.green = avg4(w.l, w.rt, w.u, w.d);
                    o.blue  = avg4(w.ul, w.ur, w.dl, w.dr);
                end else begin
                    o.green = avg2(w.l, w.u);
                    o.blue  = w.ul;
                end
            end
        end
        return o;
    endfunction

endpackage

@@ sv/bayer_bggr_bilinear_demosaic.sv @@
// bayer_bggr_bilinear_demosaic: streaming bilinear demosaic of a bggr frame
// the pixel an accepted transaction releases passes through stage a and then the registered output
// throughput: one transaction per cycle; input stalls only while the output register is held
// reset: synchronous, active low; clears counters, window, valids, size regs to 640x480
// the line store is not cleared (no clearing pass), its unwritten entries are never used
// depends on bbd_pkg
module bayer_bggr_bilinear_demosaic #(
    parameter int MAX_WIDTH = bbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  bbd_pkg::t_cfg_index            i_cfg_index,
    input  logic [bbd_pkg::CFG_BITS-1:0]   i_cfg_data,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  bbd_pkg::t_kind                 i_kind,
    input  bbd_pkg::t_pix                  i_raw_sample,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output bbd_pkg::t_pix                  o_red,
    output bbd_pkg::t_pix                  o_green,
    output bbd_pkg::t_pix                  o_blue,
    output logic                           o_frame_last
);
    import bbd_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);   // line store address
    localparam int WW = AW + 1;              // column counts, hold the width itself

    // size registers
    logic [FW_BITS-1:0]  r_frame_width;
    logic [FH_BITS-1:0]  r_frame_height;

    // input and output position
    logic [WW-1:0]       r_in_col, n_in_col;
    logic [ROW_BITS-1:0] r_in_row, n_in_row;
    logic [AW-1:0]       r_out_col, n_out_col;
    logic [ROW_BITS-1:0] r_out_row, n_out_row;
    logic                r_draining, n_draining;

    // stage a: one transaction whose line store read is in flight
    logic                r_a_valid;
    logic                r_a_emit;
    logic [AW-1:0]       r_a_x;
    t_pix                r_a_val;
    t_pix_pos            r_a_pos;
    logic                r_a_last;
    logic                r_fwd;
    t_pix                r_fwd_top, r_fwd_mid;
    t_pix                r_top_rd, r_mid_rd;

    // line store, low half is the previous row, high half the row before
    t_pix                r_line_lo [MAX_WIDTH];
    t_pix                r_line_hi [MAX_WIDTH];

    t_win                r_win, n_win;

    // output register
    logic                r_o_valid;
    t_rgb                r_o_rgb;
    logic                r_o_last;

    // effective frame size
    logic [WW-1:0]       w_cap, eff_w, w_m1;
    logic [FH_BITS-1:0]  h_cap, eff_h, h_m1;

    always_comb begin
        if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_cap = WW'(MAX_WIDTH);
        end else begin
            w_cap = WW'(r_frame_width);
        end
        eff_w = {w_cap[WW-1:1], 1'b0};
        if (eff_w < WW'(2)) begin
            eff_w = WW'(2);
        end
        w_m1 = eff_w - WW'(1);

        if (r_frame_height > FH_BITS'(HEIGHT_LIMIT)) begin
            h_cap = FH_BITS'(HEIGHT_LIMIT);
        end else begin
            h_cap = r_frame_height;
        end
        eff_h = {h_cap[FH_BITS-1:1], 1'b0};
        if (eff_h < FH_BITS'(2)) begin
            eff_h = FH_BITS'(2);
        end
        h_m1 = eff_h - FH_BITS'(1);
    end

    // handshakes
    logic a_go, in_acc, drop, take;

    // stage a moves on unless it carries a pixel and the output is held
    assign a_go       = r_a_valid && (!r_a_emit || !r_o_valid || !i_out_stall);
    assign o_in_stall = r_a_valid && !a_go;
    assign in_acc     = i_in_valid && !o_in_stall;
    // drain tick outside a drain and sample inside one leave no trace
    assign drop       = (i_kind == KIND_DRAIN) != r_draining;
    assign take       = in_acc && !drop;

    // position bookkeeping for the transaction being accepted
    logic [AW-1:0] x_new;
    t_pix          val_new;
    logic          emit_new, last_new;
    t_pix_pos      pos_new;
    logic [WW-1:0] col_inc;

    always_comb begin
        x_new   = (r_in_col < eff_w) ? r_in_col[AW-1:0] : '0;
        val_new = (i_kind == KIND_DRAIN) ? '0 : i_raw_sample;
        col_inc = r_in_col + WW'(1);

        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_draining = r_draining;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;

        if (!r_draining) begin
            // a pixel is due once one row and one sample are in
            emit_new = (r_in_row >= ROW_BITS'(2))
                    || (r_in_row == ROW_BITS'(1) && r_in_col != '0);
            if (col_inc >= eff_w) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_BITS'(1);
            end else begin
                n_in_col = col_inc;
            end
            // last sample of the frame starts the drain
            if ({1'b0, r_in_row} > h_m1
                || ({1'b0, r_in_row} == h_m1 && r_in_col >= w_m1)) begin
                n_in_col   = '0;
                n_in_row   = '0;
                n_draining = 1'b1;
            end
        end else begin
            emit_new = 1'b1;
            n_in_col = col_inc;
        end

        pos_new.row_odd    = r_out_row[0];
        pos_new.col_odd    = r_out_col[0];
        pos_new.not_top    = r_out_row != '0;
        pos_new.not_left   = r_out_col != '0;
        pos_new.not_right  = {1'b0, r_out_col} != w_m1;
        pos_new.not_bottom = {1'b0, r_out_row} != h_m1;
        last_new = !pos_new.not_right && !pos_new.not_bottom;

        if (emit_new) begin
            if (!pos_new.not_right) begin
                n_out_col = '0;
                n_out_row = r_out_row + ROW_BITS'(1);
            end else begin
                n_out_col = r_out_col + AW'(1);
            end
            // final pixel restarts the frame
            if (last_new) begin
                n_in_col   = '0;
                n_in_row   = '0;
                n_out_col  = '0;
                n_out_row  = '0;
                n_draining = 1'b0;
            end
        end
    end

    // size registers and frame position; a register write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_draining     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_BITS-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default:          r_frame_width  <= r_frame_width;
            endcase
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_draining <= 1'b0;
        end else if (take) begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_draining <= n_draining;
        end
    end

    // line store column after forwarding the write that shared the read edge
    t_pix a_top, a_mid;
    assign a_top = r_fwd ? r_fwd_top : r_top_rd;
    assign a_mid = r_fwd ? r_fwd_mid : r_mid_rd;

    // stage a control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (take) begin
            r_a_valid <= 1'b1;
        end else if (a_go) begin
            r_a_valid <= 1'b0;
        end
    end

    // stage a payload, read issued at accept, write-back when stage a retires
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_emit  <= emit_new;
            r_a_x     <= x_new;
            r_a_val   <= val_new;
            r_a_pos   <= pos_new;
            r_a_last  <= last_new;
            // same column written on this edge: the read sees old data
            r_fwd     <= a_go && (r_a_x == x_new);
            r_fwd_top <= a_mid;
            r_fwd_mid <= r_a_val;
            r_top_rd  <= r_line_hi[x_new];
            r_mid_rd  <= r_line_lo[x_new];
        end
        if (a_go) begin
            r_line_hi[r_a_x] <= a_mid;
            r_line_lo[r_a_x] <= r_a_val;
        end
    end

    // window shifts left, new column enters on the right
    always_comb begin
        n_win    = r_win;
        n_win.ul = r_win.u;
        n_win.u  = r_win.ur;
        n_win.ur = a_top;
        n_win.l  = r_win.c;
        n_win.c  = r_win.rt;
        n_win.rt = a_mid;
        n_win.dl = r_win.d;
        n_win.d  = r_win.dr;
        n_win.dr = r_a_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (a_go) begin
            r_win <= n_win;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_go && r_a_emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_go && r_a_emit) begin
            r_o_rgb  <= demosaic(n_win, r_a_pos);
            r_o_last <= r_a_last;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_red        = r_o_rgb.red;
    assign o_green      = r_o_rgb.green;
    assign o_blue       = r_o_rgb.blue;
    assign o_frame_last = r_o_last;

endmodule

@@ sv/bbd_checker.sv @@
// bbd_checker: port-level assertions for the bggr demosaic block
// bound to bayer_bggr_bilinear_demosaic; depends on bbd_pkg
module bbd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input bbd_pkg::t_pix o_red,
    input bbd_pkg::t_pix o_green,
    input bbd_pkg::t_pix o_blue,
    input logic          o_frame_last
);
    import bbd_pkg::*;

    // a reset edge empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // input only backs up behind a held output transaction
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with output free");

    // the next frame needs a row and a sample before its first pixel
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_frame_last) |=> !o_out_valid)
        else $error("pixel right after frame end");

    // held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_red)
            && $stable(o_green) && $stable(o_blue) && $stable(o_frame_last)))
        else $error("stalled output transaction changed");

endmodule

bind bayer_bggr_bilinear_demosaic bbd_checker u_bbd_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// testbench: self-checking bench for bayer_bggr_bilinear_demosaic, with a
// queue-fed driver, a pixel monitor and a bit-true demosaic predictor
// depends on bbd_pkg and the bayer_bggr_bilinear_demosaic rtl
module testbench;

    import bbd_pkg::*;

    localparam int          CLK_PERIOD    = 10;
    localparam int          RESET_CYCLES  = 10;
    localparam int unsigned LINE_W        = MAX_WIDTH_DEF;
    localparam int          SETTLE_CYCLES = 8;     // pipeline settle before a register write
    localparam int          DRAIN_WAIT    = 16;    // extra cycles after the last pixel
    localparam int          QUIET_LIMIT   = 2000;  // cycles with no transaction at all
    localparam int          LONG_HOLD     = 300;   // one long back-pressure stretch
    localparam int          RANDOM_ITEMS  = 400;
    localparam int          HOLD_AFTER    = 200;   // random items before the long hold
    localparam int          EDGE_SAMPLES  = 40;    // samples into the widest and tallest frame
    localparam int          REPORT_LIMIT  = 10;

    typedef struct packed {
        t_kind kind;
        t_pix  raw;
    } t_raw_item;

    typedef struct packed {
        t_pix red;
        t_pix green;
        t_pix blue;
        logic last;
    } t_pixel;

    // dut ports, the inputs all known from time zero
    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_cfg_we     = 1'b0;
    t_cfg_index          i_cfg_index  = CFG_FRAME_WIDTH;
    logic [CFG_BITS-1:0] i_cfg_data   = '0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_stall;
    t_kind               i_kind       = KIND_SAMPLE;
    t_pix                i_raw_sample = '0;
    logic                o_out_valid;
    logic                i_out_stall  = 1'b0;
    t_pix                o_red;
    t_pix                o_green;
    t_pix                o_blue;
    logic                o_frame_last;

    bayer_bggr_bilinear_demosaic #(
        .MAX_WIDTH(LINE_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_raw_sample (i_raw_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_frame_last (o_frame_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor state: size registers, two line buffers, 3x3 window,
    // input and output raster positions
    // ------------------------------------------------------------------
    logic [FW_BITS-1:0] reg_width  = WIDTH_RESET;
    logic [FH_BITS-1:0] reg_height = HEIGHT_RESET;
    t_pix               line_mem [0:2*LINE_W-1];
    t_pix               win [0:2][0:2];
    int unsigned        col_in   = 0;
    int unsigned        row_in   = 0;
    int unsigned        out_idx  = 0;
    bit                 in_drain = 1'b0;

    t_raw_item   raw_items [$];    // transactions waiting for the driver
    t_pixel      pixel_queue [$];  // predicted pixels, oldest first
    int unsigned error_count  = 0;
    int unsigned quiet_cycles = 0;
    logic        in_fire_q    = 1'b0;
    bit          idling       = 1'b0;
    bit          long_hold_req = 1'b0;
    bit          long_hold_ack = 1'b0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned hold_left    = 0;

    function automatic int unsigned eff_width();
        int unsigned w;
        w = 32'(reg_width);
        if (w > LINE_W) w = LINE_W;
        w = w & 32'hFFFF_FFFE;
        if (w < 2) w = 2;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = 32'(reg_height);
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        h = h & 32'hFFFF_FFFE;
        if (h < 2) h = 2;
        return h;
    endfunction

    function automatic void restart_frame();
        col_in   = 0;
        row_in   = 0;
        out_idx  = 0;
        in_drain = 1'b0;
    endfunction

    // bilinear rgb for the window center at (row, col) of a bggr frame
    function automatic t_pixel interpolate(int unsigned row, int unsigned col,
                                           int unsigned w, int unsigned h);
        t_pixel      p;
        int unsigned ul, u, ur, l, c, rt, dl, d, dr;
        ul = win[0][0]; u = win[0][1]; ur = win[0][2];
        l  = win[1][0]; c = win[1][1]; rt = win[1][2];
        dl = win[2][0]; d = win[2][1]; dr = win[2][2];
        p = '0;
        if ((row & 1) == 0) begin
            if ((col & 1) == 0) begin
                // blue site, top row and left column copy from one side
                if (row > 0 && col > 0) begin
                    p.red   = 8'((ul + ur + dl + dr) / 4);
                    p.green = 8'((l + rt + d + u) / 4);
                end else begin
                    p.red   = 8'(dr);
                    p.green = 8'((rt + d) / 2);
                end
                p.blue = 8'(c);
            end else begin
                p.green = 8'(c);
                if (row > 0 && col < w - 1) begin
                    p.red  = 8'((d + u) / 2);
                    p.blue = 8'((l + rt) / 2);
                end else begin
                    p.red  = 8'(d);
                    p.blue = 8'(l);
                end
            end
        end else begin
            if ((col & 1) == 0) begin
                p.green = 8'(c);
                if (row < h - 1 && col > 0) begin
                    p.red  = 8'((l + rt) / 2);
                    p.blue = 8'((d + u) / 2);
                end else begin
                    p.red  = 8'(rt);
                    p.blue = 8'(u);
                end
            end else begin
                // red site, bottom row and right column copy from one side
                p.red = 8'(c);
                if (row < h - 1 && col < w - 1) begin
                    p.green = 8'((l + rt + u + d) / 4);
                    p.blue  = 8'((ul + ur + dl + dr) / 4);
                end else begin
                    p.green = 8'((l + u) / 2);
                    p.blue  = 8'(ul);
                end
            end
        end
        return p;
    endfunction

    // advances the predictor by one accepted input transaction
    task automatic demosaic_step(input t_kind kind, input t_pix raw,
                                 output bit emit, output t_pixel px);
        int unsigned w, h, total, x, received, k;
        t_pix        top, mid, val;
        w     = eff_width();
        h     = eff_height();
        total = w * h;
        emit  = 1'b0;
        px    = '0;
        // drain tick outside a drain and sample during a drain do nothing
        if ((kind == KIND_DRAIN) != in_drain) return;
        x   = (col_in < w) ? col_in : 0;
        val = (kind == KIND_DRAIN) ? 8'h00 : raw;
        top = line_mem[LINE_W + x];
        mid = line_mem[x];
        line_mem[LINE_W + x] = mid;
        line_mem[x]          = val;
        for (k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = val;
        if (!in_drain) begin
            received = row_in * w + col_in;
            emit = (received >= w + 1);
            col_in++;
            if (col_in >= w) begin
                col_in = 0;
                row_in++;
            end
            if (received >= total - 1) begin
                col_in   = 0;
                row_in   = 0;
                in_drain = 1'b1;
            end
        end else begin
            emit = 1'b1;
            col_in++;
        end
        if (!emit) return;
        px      = interpolate(out_idx / w, out_idx % w, w, h);
        px.last = (out_idx >= total - 1);
        out_idx++;
        if (px.last) restart_frame();
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_pix rand_level();
        t_pix v;
        v = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return v;
    endfunction

    function automatic void push_item(input t_kind kind, input t_pix raw);
        t_raw_item it;
        it.kind = kind;
        it.raw  = raw;
        raw_items.push_back(it);
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_width_raw();
        logic [CFG_BITS-1:0] v;
        int unsigned         sel;
        sel = $urandom_range(0, 9);
        v   = CFG_BITS'(2 * $urandom_range(1, 8));
        if (sel == 7) v = CFG_BITS'(2 * $urandom_range(0, 7) + 1);  // odd, low bit dropped
        else if (sel == 8) v = v | 13'h1000;                // bit above the register
        else if (sel == 9) v = '0;                          // below the minimum
        return v;
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_height_raw();
        logic [CFG_BITS-1:0] v;
        int unsigned         sel;
        sel = $urandom_range(0, 9);
        v   = CFG_BITS'(2 * $urandom_range(1, 4));
        if (sel == 7) v = CFG_BITS'(2 * $urandom_range(0, 4) + 1);
        else if (sel == 8) v = '0;
        return v;
    endfunction

    // everything sent, every pixel back, then let the pipeline settle
    task automatic wait_idle();
        while (raw_items.size() != 0 || i_in_valid || pixel_queue.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [CFG_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_FRAME_WIDTH) reg_width = data[FW_BITS-1:0];
        else reg_height = data[FH_BITS-1:0];
        restart_frame();
    endtask

    task automatic set_frame(input logic [CFG_BITS-1:0] w_raw, input logic [CFG_BITS-1:0] h_raw);
        wait_idle();
        write_register(CFG_FRAME_WIDTH, w_raw);
        write_register(CFG_FRAME_HEIGHT, h_raw);
    endtask

    // one frame of random samples plus its drain ticks; a partial frame is
    // cut short anywhere in that sequence and must be followed by a write
    task automatic queue_frame(input bit noisy, input bit partial, output int unsigned count);
        int unsigned w, n, span, cut, i;
        w     = eff_width();
        n     = w * eff_height();
        span  = n + w + 1;
        cut   = partial ? $urandom_range(1, span - 1) : span;
        count = 0;
        if (noisy && $urandom_range(0, 1)) push_item(KIND_DRAIN, rand_level());
        for (i = 0; i < cut; i++) begin
            if (i < n) begin
                push_item(KIND_SAMPLE, rand_level());
            end else begin
                if (noisy && $urandom_range(0, 5) == 0) push_item(KIND_SAMPLE, rand_level());
                push_item(KIND_DRAIN, rand_level());
            end
            count++;
        end
        if (noisy && !partial) push_item(KIND_DRAIN, rand_level());
    endtask

    // ------------------------------------------------------------------
    // input driver: presents the next raw transaction at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : raw_driver
        t_raw_item nxt;
        if (!i_in_valid || in_fire_q) begin
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (idling && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(0, 3);
                i_in_valid <= 1'b0;
            end else if (raw_items.size() != 0) begin
                nxt = raw_items.pop_front();
                i_kind       <= nxt.kind;
                i_raw_sample <= nxt.raw;
                i_in_valid   <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output back-pressure: short random bursts, plus one long hold on request
    always @(negedge i_clk) begin : out_stall_gen
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (long_hold_req != long_hold_ack) begin
            long_hold_ack = long_hold_req;
            hold_left = LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idling && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: check the output transaction, then predict from the input one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : pixel_monitor
        t_pixel seen, want, fresh;
        bit     emit, in_fire, out_fire;
        if (i_rst_n) begin
            in_fire  = i_in_valid && !o_in_stall;
            out_fire = o_out_valid && !i_out_stall;
            if (out_fire) begin
                seen = '{o_red, o_green, o_blue, o_frame_last};
                if (pixel_queue.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: pixel with none expected: r=%0d g=%0d b=%0d last=%0d",
                                 $realtime, seen.red, seen.green, seen.blue, seen.last);
                end else begin
                    want = pixel_queue.pop_front();
                    if (seen !== want) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("%0t: mismatch exp r=%0d g=%0d b=%0d last=%0d, %s",
                                     $realtime, want.red, want.green, want.blue, want.last,
                                     $sformatf("got r=%0d g=%0d b=%0d last=%0d",
                                               seen.red, seen.green, seen.blue, seen.last));
                    end
                end
            end
            if (in_fire) begin
                demosaic_step(i_kind, i_raw_sample, emit, fresh);
                if (emit) pixel_queue.push_back(fresh);
            end
            in_fire_q <= in_fire;
            quiet_cycles <= (in_fire || out_fire) ? 0 : quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("testbench: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : sequencer
        int unsigned items_sent, count, i;
        bit          partial, restart_due, hold_done;
        items_sent  = 0;
        restart_due = 1'b0;
        hold_done   = 1'b0;
        for (i = 0; i < 2 * LINE_W; i++) line_mem[i] = '0;
        for (i = 0; i < 9; i++) win[i / 3][i % 3] = '0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // a few samples at the reset size of 640x480: no pixel is due yet
        repeat (30) push_item(KIND_SAMPLE, rand_level());

        // directed 4x2 frame with full-scale checkerboard samples
        set_frame(13'd4, 13'd2);
        push_item(KIND_DRAIN, 8'h00);          // drain tick with no drain running
        for (i = 0; i < 8; i++)
            push_item(KIND_SAMPLE, (((i ^ (i >> 2)) & 1) != 0) ? 8'h00 : 8'hFF);
        push_item(KIND_DRAIN, 8'hFF);
        push_item(KIND_SAMPLE, 8'hFF);         // sample during the drain
        repeat (4) push_item(KIND_DRAIN, 8'h00);
        push_item(KIND_DRAIN, 8'hFF);          // after the frame-last pixel

        // smallest frame, reached through masked and clamped register values
        set_frame(13'h1002, 13'd1);
        queue_frame(1'b0, 1'b0, count);

        // random frames: mostly well formed, some noisy, some cut short
        while (items_sent < RANDOM_ITEMS) begin
            idling = ($urandom_range(0, 3) != 0);
            if (!hold_done && items_sent >= HOLD_AFTER) begin
                // receiver holds off while the sender keeps offering
                set_frame(13'd16, 13'd8);
                queue_frame(1'b0, 1'b0, count);
                long_hold_req = !long_hold_req;
                hold_done = 1'b1;
                restart_due = 1'b0;
                wait_idle();
            end else begin
                if (restart_due || $urandom_range(0, 1)) set_frame(pick_width_raw(), pick_height_raw());
                partial = ($urandom_range(0, 4) == 0);
                queue_frame(1'($urandom_range(0, 1)), partial, count);
                restart_due = partial;
            end
            items_sent += count;
        end

        // start of the widest and of the tallest frame, from saturated register values
        idling = 1'b1;
        set_frame(13'd4095, 13'd2);
        repeat (EDGE_SAMPLES) push_item(KIND_SAMPLE, rand_level());
        set_frame(13'd2, 13'd8191);
        repeat (EDGE_SAMPLES) push_item(KIND_SAMPLE, rand_level());

        // closing stretch with no idling on either side
        idling = 1'b0;
        repeat (4) begin
            set_frame(pick_width_raw(), pick_height_raw());
            queue_frame(1'b0, 1'b0, count);
        end

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0 && pixel_queue.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
